/* rtl/core/estc_pkg.sv */
// ============================================================================
// estc_pkg: shared constants for the elapsed seconds to calendar unit.
// Holds the divisors, the divide step counts, the register map and the
// month length lookup.
// ============================================================================
`timescale 1ns / 1ps

package estc_pkg;

    // Width of the divider remainder; the largest divisor fits in 25 bits.
    localparam int unsigned REM_W = 25;

    localparam logic [REM_W-1:0] SECS_PER_YEAR   = 25'd31536000;
    localparam logic [REM_W-1:0] SECS_PER_DAY    = 25'd86400;
    localparam logic [REM_W-1:0] SECS_PER_HOUR   = 25'd3600;
    localparam logic [REM_W-1:0] SECS_PER_MINUTE = 25'd60;

    localparam logic [4:0] MONTHS_PER_YEAR = 5'd12;

    // Number of divide steps less one for each stage (dividend width - 1).
    localparam logic [4:0] STEPS_YEAR   = 5'd31;
    localparam logic [4:0] STEPS_DAY    = 5'd24;
    localparam logic [4:0] STEPS_HOUR   = 5'd16;
    localparam logic [4:0] STEPS_MINUTE = 5'd11;

    // Register map, indexed by paddr[3:2].
    typedef enum logic [1:0] {
        REG_START_YEAR  = 2'd0,
        REG_START_MONTH = 2'd1,
        REG_START_DAY   = 2'd2
    } reg_index_t;

    // Days in a month; anything that is not a 30- or 28-day month has 31.
    function automatic logic [4:0] month_length(input logic [3:0] m);
        logic [4:0] len;
        if (m inside {4'd4, 4'd6, 4'd9, 4'd11})
        begin
            len = 5'd30;
        end
        else if (m == 4'd2)
        begin
            len = 5'd28;
        end
        else
        begin
            len = 5'd31;
        end
        return len;
    endfunction

endpackage

/* rtl/core/elapsed_seconds_to_calendar_unit.sv */
// ============================================================================
// elapsed_seconds_to_calendar_unit: elapsed seconds to calendar date.
// Each item takes 86 one-bit divide steps, a month walk and a load of the result registers.
// One item in flight: a new item is taken only when idle, after the last result is loaded.
// The divider is one shared one-bit restoring divider; the month walk takes up to 13 month steps.
// Async reset (rst_n) clears control and sets the start date to 2003-02-01.
// ============================================================================
`timescale 1ns / 1ps

module elapsed_seconds_to_calendar_unit
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // Input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] elapsed_seconds,

    // Result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [12:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second
);

    import estc_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DIV_YEAR,
        PH_DIV_DAY,
        PH_DIV_HOUR,
        PH_DIV_MIN,
        PH_WALK,
        PH_DONE
    } phase_t;

    phase_t       phase_reg;
    logic [4:0]   count_reg;
    logic         out_valid_reg;
    logic [11:0]  start_year_reg;
    logic [3:0]   start_month_reg;
    logic [4:0]   start_day_reg;

    logic [REM_W-1:0] rem_reg;
    logic [31:0]      quo_reg;
    logic [12:0]      work_year_reg;
    logic [3:0]       work_month_reg;
    logic [8:0]       work_day_reg;
    logic [4:0]       hour_reg;
    logic [5:0]       minute_reg;
    logic [5:0]       second_reg;
    logic [12:0]      year_out_reg;
    logic [3:0]       month_out_reg;
    logic [4:0]       day_out_reg;
    logic [4:0]       hour_out_reg;
    logic [5:0]       minute_out_reg;
    logic [5:0]       second_out_reg;

    logic             in_fire;
    logic             cfg_write;
    reg_index_t       cfg_index;
    logic             out_free;
    logic             step_last;
    logic [REM_W-1:0] divisor;
    logic [REM_W:0]   shifted;
    logic [REM_W+1:0] trial;
    logic [REM_W-1:0] step_rem;
    logic [31:0]      step_quo;
    logic [4:0]       walk_len;
    logic             walk_more;
    logic [4:0]       month_inc;

    // Handshakes.
    assign in_ready  = (phase_reg == PH_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[3:2]);
    assign step_last = (count_reg == 5'd0);

    // Register read-back.
    always_comb
    begin
        case (cfg_index)
            REG_START_YEAR:  prdata = {20'd0, start_year_reg};
            REG_START_MONTH: prdata = {28'd0, start_month_reg};
            REG_START_DAY:   prdata = {27'd0, start_day_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // Divisor for the current stage of the shared divider.
    always_comb
    begin
        case (phase_reg)
            PH_DIV_YEAR: divisor = SECS_PER_YEAR;
            PH_DIV_DAY:  divisor = SECS_PER_DAY;
            PH_DIV_HOUR: divisor = SECS_PER_HOUR;
            default:     divisor = SECS_PER_MINUTE;
        endcase
    end

    // One restoring divide step: bring in the next dividend bit and try a subtract.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[31]};
        trial    = {1'b0, shifted} - {2'b00, divisor};
        if (!trial[REM_W+1])
        begin
            step_rem = trial[REM_W-1:0];
        end
        else
        begin
            step_rem = shifted[REM_W-1:0];
        end
        step_quo = {quo_reg[30:0], !trial[REM_W+1]};
    end

    // One month step of the walk.
    assign walk_len  = month_length(work_month_reg);
    assign walk_more = (work_day_reg > {4'd0, walk_len});
    assign month_inc = {1'b0, work_month_reg} + 5'd1;

    // Control state machine, configuration registers and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            count_reg       <= 5'd0;
            out_valid_reg   <= 1'b0;
            start_year_reg  <= 12'd2003;
            start_month_reg <= 4'd2;
            start_day_reg   <= 5'd1;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_START_YEAR:  start_year_reg  <= pwdata[11:0];
                    REG_START_MONTH: start_month_reg <= pwdata[3:0];
                    REG_START_DAY:   start_day_reg   <= pwdata[4:0];
                    default:         ;
                endcase
            end

            // Result valid rises when a finished item is loaded and falls when taken.
            if ((phase_reg == PH_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (phase_reg)
                PH_IDLE:
                begin
                    if (in_fire)
                    begin
                        phase_reg <= PH_DIV_YEAR;
                        count_reg <= STEPS_YEAR;
                    end
                end
                PH_DIV_YEAR:
                begin
                    count_reg <= step_last ? STEPS_DAY : count_reg - 5'd1;
                    if (step_last)
                    begin
                        phase_reg <= PH_DIV_DAY;
                    end
                end
                PH_DIV_DAY:
                begin
                    count_reg <= step_last ? STEPS_HOUR : count_reg - 5'd1;
                    if (step_last)
                    begin
                        phase_reg <= PH_DIV_HOUR;
                    end
                end
                PH_DIV_HOUR:
                begin
                    count_reg <= step_last ? STEPS_MINUTE : count_reg - 5'd1;
                    if (step_last)
                    begin
                        phase_reg <= PH_DIV_MIN;
                    end
                end
                PH_DIV_MIN:
                begin
                    count_reg <= step_last ? 5'd0 : count_reg - 5'd1;
                    if (step_last)
                    begin
                        phase_reg <= PH_WALK;
                    end
                end
                PH_WALK:
                begin
                    if (!walk_more)
                    begin
                        phase_reg <= PH_DONE;
                    end
                end
                PH_DONE:
                begin
                    if (out_free)
                    begin
                        phase_reg <= PH_IDLE;
                    end
                end
                default:
                begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    // Datapath: divider registers, working date and result registers.
    always_ff @(posedge clk)
    begin
        case (phase_reg)
            PH_IDLE:
            begin
                if (in_fire)
                begin
                    quo_reg <= elapsed_seconds;
                    rem_reg <= '0;
                end
            end
            PH_DIV_YEAR:
            begin
                if (step_last)
                begin
                    // Whole years go on the start year; the remainder is realigned.
                    work_year_reg <= {1'b0, start_year_reg} + {5'd0, step_quo[7:0]};
                    quo_reg       <= {step_rem[24:0], 7'd0};
                    rem_reg       <= '0;
                end
                else
                begin
                    rem_reg <= step_rem;
                    quo_reg <= step_quo;
                end
            end
            PH_DIV_DAY:
            begin
                if (step_last)
                begin
                    work_day_reg   <= step_quo[8:0] + {4'd0, start_day_reg};
                    work_month_reg <= start_month_reg;
                    quo_reg        <= {step_rem[16:0], 15'd0};
                    rem_reg        <= '0;
                end
                else
                begin
                    rem_reg <= step_rem;
                    quo_reg <= step_quo;
                end
            end
            PH_DIV_HOUR:
            begin
                if (step_last)
                begin
                    hour_reg <= step_quo[4:0];
                    quo_reg  <= {step_rem[11:0], 20'd0};
                    rem_reg  <= '0;
                end
                else
                begin
                    rem_reg <= step_rem;
                    quo_reg <= step_quo;
                end
            end
            PH_DIV_MIN:
            begin
                rem_reg <= step_rem;
                quo_reg <= step_quo;
                if (step_last)
                begin
                    minute_reg <= step_quo[5:0];
                    second_reg <= step_rem[5:0];
                end
            end
            PH_WALK:
            begin
                // Take off a whole month and roll the year after December.
                if (walk_more)
                begin
                    work_day_reg <= work_day_reg - {4'd0, walk_len};
                    if (month_inc > MONTHS_PER_YEAR)
                    begin
                        work_month_reg <= 4'd1;
                        work_year_reg  <= work_year_reg + 13'd1;
                    end
                    else
                    begin
                        work_month_reg <= month_inc[3:0];
                    end
                end
            end
            PH_DONE:
            begin
                if (out_free)
                begin
                    year_out_reg   <= work_year_reg;
                    month_out_reg  <= work_month_reg;
                    day_out_reg    <= work_day_reg[4:0];
                    hour_out_reg   <= hour_reg;
                    minute_out_reg <= minute_reg;
                    second_out_reg <= second_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign year      = year_out_reg;
    assign month     = month_out_reg;
    assign day       = day_out_reg;
    assign hour      = hour_out_reg;
    assign minute    = minute_out_reg;
    assign second    = second_out_reg;

    // The time of day held for delivery is always within range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hour < 5'd24) && (minute < 6'd60) && (second < 6'd60))
    else $error("time of day out of range on the result channel");

    // The month walk only ever shrinks a day count that starts below 396.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WALK) |-> (work_day_reg <= 9'd395))
    else $error("day count out of range during the month walk");

    // A finished item with room on the result side is offered next cycle, and the unit is then ready for a new item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE) && out_free |=> out_valid && in_ready)
    else $error("finished item not delivered");

endmodule
